FILE: design/server_list_token_parser_macros.svh
// Assertion macros shared by the server list token parser RTL.
`ifndef SERVER_LIST_TOKEN_PARSER_MACROS_SVH
`define SERVER_LIST_TOKEN_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLTP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/sltp_pkg.sv
// Types and constants of the server list token parser.
package sltp_pkg;

	// Input item: one list byte and its end-of-list flag
	typedef struct packed {
		logic [7:0] list_byte;
		logic       end_of_list;
	} sltp_in_t;

	// Result item: one per token, or the fallback marker
	typedef struct packed {
		logic [5:0]  entry_index;
		logic [1:0]  entry_status;
		logic [15:0] entry_port;
		logic [7:0]  host_length;
		logic        list_fallback;
		logic        last_of_list;
	} sltp_out_t;

	typedef enum logic [1:0] {
		ST_PROBE       = 2'd0,
		ST_MALFORMED   = 2'd1,
		ST_PORT_DENIED = 2'd2,
		ST_OVER_CAP    = 2'd3
	} sltp_status_t;

	localparam logic [15:0] PORT_DEFAULT = 16'd80;
	localparam logic [15:0] PORT_TLS     = 16'd443;
	localparam logic [15:0] PORT_ALT     = 16'd8000;
	localparam logic [19:0] PORT_MAX     = 20'd65535;
	localparam logic [7:0]  CHAR_COLON   = 8'h3A;
	localparam logic [7:0]  CHAR_COMMA   = 8'h2C;
	localparam logic [6:0]  PROBE_LIMIT_RESET = 7'd16;

endpackage

FILE: design/server_list_token_parser.sv
// Server list token parser: scans list bytes and emits one result per token.
//
// The block takes one byte of a comma-separated server list per cycle, unless stalled, and keeps
// only running scanner state (phase, host length, port value, token index). A
// byte is held in the input register until the queue has room for its results, which go
// into a four-entry output queue; a token's closing byte is registered at the input and
// its first result is registered in the queue before it is offered.
// Input is accepted every cycle as long as the queue has room for two results,
// which is what a trailing comma can produce; with the output side taking results
// steadily the sustained rate is one byte per cycle, as the scanner state is updated
// on every accepted byte. probe_limit is written through cfg_we/cfg_data and resets to 16.
`include "server_list_token_parser_macros.svh"

module server_list_token_parser
	import sltp_pkg::*;
#(
	parameter int MAX_ENTRIES   = 64,
	parameter int HOST_CAPACITY = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sltp_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output sltp_out_t out_data,
	input  logic      cfg_we,
	input  logic [6:0] cfg_data
);

	localparam int HW = $clog2(HOST_CAPACITY);
	localparam int TW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (TW > 7) ? TW : 7;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		PH_HOST,
		PH_PORT,
		PH_BAD
	} phase_t;

	// Close one token into a result item
	function automatic sltp_out_t close_token(phase_t ph, logic [HW-1:0] hc,
			logic [15:0] acc, logic seen, logic [TW-1:0] idx, logic last,
			logic [6:0] lim);
		sltp_out_t r;
		logic bad;
		logic [15:0] port;
		r = '0;
		bad = (ph == PH_BAD) || (hc == '0);
		port = PORT_DEFAULT;
		if (!bad && seen) begin
			port = acc;
			if (acc == 16'd0) begin
				bad = 1'b1;
			end
		end
		if (int'(idx) >= MAX_ENTRIES) begin
			r.list_fallback = 1'b1;
			r.last_of_list = 1'b1;
		end else if (bad) begin
			r.entry_index = 6'(idx);
			r.entry_status = ST_MALFORMED;
			r.last_of_list = last;
		end else begin
			r.entry_index = 6'(idx);
			if (CW'(idx) >= CW'(lim)) begin
				r.entry_status = ST_OVER_CAP;
			end else if (port == PORT_DEFAULT || port == PORT_TLS || port == PORT_ALT) begin
				r.entry_status = ST_PROBE;
			end else begin
				r.entry_status = ST_PORT_DENIED;
			end
			r.entry_port = port;
			r.host_length = 8'(hc);
			r.last_of_list = last;
		end
		return r;
	endfunction

	// Configuration register
	logic [6:0] probe_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_limit_q <= PROBE_LIMIT_RESET;
		end else if (cfg_we) begin
			probe_limit_q <= cfg_data;
		end
	end

	// Input register
	logic     valid_s1;
	sltp_in_t data_s1;
	logic     fire;
	logic [QAW:0] cnt_q;

	assign fire = valid_s1 && (int'(cnt_q) <= QDEPTH - 2);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Scanner state
	phase_t          phase_q;
	logic [HW-1:0]   host_count_q;
	logic [15:0]     port_acc_q;
	logic            seen_colon_q;
	logic [TW-1:0]   token_count_q;
	logic            discarding_q;

	logic [7:0]  c;
	logic        eol;
	logic        is_comma;
	logic        is_digit;
	logic        is_host;
	logic [19:0] acc_next;
	phase_t          phase_f;
	logic [HW-1:0]   hc_f;
	logic [15:0]     acc_f;
	logic            seen_f;
	sltp_out_t   res0;
	sltp_out_t   res1;
	logic        push0;
	logic        push1;

	assign c = data_s1.list_byte;
	assign eol = data_s1.end_of_list;
	assign is_comma = (c == CHAR_COMMA);
	assign is_digit = c inside {["0":"9"]};
	assign is_host = c inside {["a":"z"], ["A":"Z"], ["0":"9"], ".", "-"};
	assign acc_next = ({4'd0, port_acc_q} << 3) + ({4'd0, port_acc_q} << 1) + {16'd0, c[3:0]};

	// Take a non-comma byte into the open token
	always_comb begin
		phase_f = phase_q;
		hc_f = host_count_q;
		acc_f = port_acc_q;
		seen_f = seen_colon_q;
		case (phase_q)
			PH_HOST: begin
				if (is_host) begin
					if (({1'b0, host_count_q} + 1'b1) >= (HW+1)'(HOST_CAPACITY)) begin
						phase_f = PH_BAD;
					end else begin
						hc_f = host_count_q + 1'b1;
					end
				end else if (c == CHAR_COLON && host_count_q != '0) begin
					phase_f = PH_PORT;
					seen_f = 1'b1;
				end else begin
					phase_f = PH_BAD;
				end
			end
			PH_PORT: begin
				if (is_digit) begin
					acc_f = acc_next[15:0];
					if (acc_next > PORT_MAX) begin
						phase_f = PH_BAD;
					end
				end else begin
					phase_f = PH_BAD;
				end
			end
			default: begin
				phase_f = PH_BAD;
			end
		endcase
	end

	// Close the open token; a trailing comma adds an empty token
	always_comb begin
		if (is_comma) begin
			res0 = close_token(phase_q, host_count_q, port_acc_q, seen_colon_q,
				token_count_q, 1'b0, probe_limit_q);
		end else begin
			res0 = close_token(phase_f, hc_f, acc_f, seen_f, token_count_q, 1'b1,
				probe_limit_q);
		end
		res1 = close_token(PH_HOST, '0, 16'd0, 1'b0, token_count_q + 1'b1, 1'b1,
			probe_limit_q);
	end

	assign push0 = fire && !discarding_q && (is_comma || eol);
	assign push1 = push0 && is_comma && eol && !res0.list_fallback;

	// Advance scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HOST;
			host_count_q <= '0;
			port_acc_q <= '0;
			seen_colon_q <= 1'b0;
			token_count_q <= '0;
			discarding_q <= 1'b0;
		end else if (fire) begin
			if (eol) begin
				phase_q <= PH_HOST;
				host_count_q <= '0;
				port_acc_q <= '0;
				seen_colon_q <= 1'b0;
				token_count_q <= '0;
				discarding_q <= 1'b0;
			end else if (discarding_q) begin
				discarding_q <= 1'b1;
			end else if (is_comma) begin
				phase_q <= PH_HOST;
				host_count_q <= '0;
				port_acc_q <= '0;
				seen_colon_q <= 1'b0;
				if (res0.list_fallback) begin
					discarding_q <= 1'b1;
				end else begin
					token_count_q <= token_count_q + 1'b1;
				end
			end else begin
				phase_q <= phase_f;
				host_count_q <= hc_f;
				port_acc_q <= acc_f;
				seen_colon_q <= seen_f;
			end
		end
	end

	// Output queue
	sltp_out_t    queue_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic         pop;
	logic [QAW:0] push_n;

	assign out_valid = (cnt_q != '0);
	assign out_data = queue_q[rp_q];
	assign pop = out_valid && out_ready;
	assign push_n = (QAW+1)'(push0) + (QAW+1)'(push1);

	always_ff @(posedge clk) begin
		if (push0) begin
			queue_q[wp_q] <= res0;
		end
		if (push1) begin
			queue_q[wp_q + 1'b1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + push_n[QAW-1:0];
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + push_n - (QAW+1)'(pop);
		end
	end

	`SLTP_ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, int'(cnt_q) <= QDEPTH, "output queue overflow")
	`SLTP_ASSERT_IMPL(a_fallback_form, clk, arst_n, out_valid && out_data.list_fallback, out_data.last_of_list && out_data.entry_index == 6'd0 && out_data.entry_status == ST_PROBE, "fallback item malformed")
	`SLTP_ASSERT_IMPL(a_malformed_zero, clk, arst_n, out_valid && out_data.entry_status == ST_MALFORMED, out_data.entry_port == 16'd0 && out_data.host_length == 8'd0, "malformed item carries data")
	`SLTP_ASSERT_NEXT(a_enter_discard, clk, arst_n, push0 && res0.list_fallback && !eol, discarding_q, "fallback did not start discard")
	`SLTP_ASSERT_IMPL(a_silent_discard, clk, arst_n, fire && discarding_q, !push0 && !push1, "item pushed while discarding")

endmodule

FILE: sim/server_list_token_parser_tb.sv
// Testbench for the server list token parser: directed and random lists checked against a predictor.
module server_list_token_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sltp_pkg::*;

	localparam int ENTRY_CAP     = 64;
	localparam int HOST_CAP      = 256;
	localparam int TOTAL_ITEMS   = 1050;
	localparam int CALM_ITEMS    = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum logic [1:0] {SCAN_HOST, SCAN_PORT, SCAN_BAD} scan_phase_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	sltp_in_t   in_data;
	logic       out_valid;
	logic       out_ready;
	sltp_out_t  out_data;
	logic       cfg_we;
	logic [6:0] cfg_data;

	// shadow of the scanner state
	scan_phase_t phase_q;
	int          host_len_q;
	int          port_val_q;
	int          entries_q;
	bit          colon_q;
	bit          dropping_q;
	logic [6:0]  probe_limit_q;

	sltp_out_t  expected_entries[$];
	logic [7:0] list_bytes[$];
	int         mismatches = 0;
	int         cycles = 0;
	int         items_sent = 0;
	bit         calm = 1'b0;

	server_list_token_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic note_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
		mismatches++;
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic bit is_host_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == "." || c == "-";
	endfunction

	function automatic void clear_token();
		phase_q = SCAN_HOST;
		host_len_q = 0;
		port_val_q = 0;
		colon_q = 1'b0;
	endfunction

	function automatic void clear_list();
		clear_token();
		entries_q = 0;
		dropping_q = 1'b0;
	endfunction

	// Close the open token into one expected entry
	function automatic void close_entry(bit final_one);
		sltp_out_t r;
		bit        bad;
		int        port;
		r = '0;
		bad = (phase_q == SCAN_BAD) || (host_len_q == 0);
		port = PORT_DEFAULT;
		// list too long: fallback marker, then drop the rest of the list
		if (entries_q >= ENTRY_CAP) begin
			r.list_fallback = 1'b1;
			r.last_of_list = 1'b1;
			expected_entries.push_back(r);
			dropping_q = 1'b1;
			clear_token();
			return;
		end
		if (!bad && colon_q) begin
			port = port_val_q;
			if (port == 0 || port > PORT_MAX)
				bad = 1'b1;
		end
		r.entry_index = entries_q[5:0];
		r.last_of_list = final_one;
		if (bad) begin
			r.entry_status = ST_MALFORMED;
		end else begin
			if (entries_q >= probe_limit_q)
				r.entry_status = ST_OVER_CAP;
			else if (port == PORT_DEFAULT || port == PORT_TLS || port == PORT_ALT)
				r.entry_status = ST_PROBE;
			else
				r.entry_status = ST_PORT_DENIED;
			r.entry_port = port[15:0];
			r.host_length = host_len_q[7:0];
		end
		expected_entries.push_back(r);
		entries_q++;
		clear_token();
	endfunction

	// Advance the scanner by one non-comma byte
	function automatic void absorb_byte(logic [7:0] c);
		case (phase_q)
			SCAN_HOST: begin
				if (is_host_char(c)) begin
					if (host_len_q + 1 >= HOST_CAP)
						phase_q = SCAN_BAD;
					else
						host_len_q++;
				end else if (c == CHAR_COLON && host_len_q != 0) begin
					phase_q = SCAN_PORT;
					colon_q = 1'b1;
				end else begin
					phase_q = SCAN_BAD;
				end
			end
			SCAN_PORT: begin
				if (c >= "0" && c <= "9") begin
					port_val_q = port_val_q * 10 + int'(c - "0");
					if (port_val_q > PORT_MAX)
						phase_q = SCAN_BAD;
				end else begin
					phase_q = SCAN_BAD;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_item(sltp_in_t it);
		if (dropping_q) begin
			if (it.end_of_list)
				clear_list();
			return;
		end
		// comma closes the token; with end of list it also yields an empty one
		if (it.list_byte == CHAR_COMMA) begin
			close_entry(1'b0);
			if (it.end_of_list) begin
				if (!dropping_q)
					close_entry(1'b1);
				clear_list();
			end
			return;
		end
		absorb_byte(it.list_byte);
		if (it.end_of_list) begin
			close_entry(1'b1);
			clear_list();
		end
	endfunction

	// ---------------------------------------------------------------- checking

	// Compare each accepted result with the oldest expected entry
	always @(posedge clk) begin : check_results
		sltp_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_entries.size() == 0) begin
				note_mismatch("result with none expected", out_data, 0);
			end else begin
				want = expected_entries.pop_front();
				if (out_data.entry_index != want.entry_index)
					note_mismatch("entry_index", out_data.entry_index, want.entry_index);
				if (out_data.entry_status != want.entry_status)
					note_mismatch("entry_status", out_data.entry_status, want.entry_status);
				if (out_data.entry_port != want.entry_port)
					note_mismatch("entry_port", out_data.entry_port, want.entry_port);
				if (out_data.host_length != want.host_length)
					note_mismatch("host_length", out_data.host_length, want.host_length);
				if (out_data.list_fallback != want.list_fallback)
					note_mismatch("list_fallback", out_data.list_fallback, want.list_fallback);
				if (out_data.last_of_list != want.last_of_list)
					note_mismatch("last_of_list", out_data.last_of_list, want.last_of_list);
			end
		end
	end

	// Stall the result side in random bursts, none once calm
	initial begin : result_pacing
		int run;
		int hold;
		out_ready = 1'b0;
		forever begin
			run = $urandom_range(1, 24);
			repeat (run) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end
			if (!calm && $urandom_range(0, 2) == 0) begin
				hold = $urandom_range(1, 11);
				repeat (hold) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// Send one item; starts and ends on a falling edge
	task automatic send_item(logic [7:0] b, logic eol);
		sltp_in_t it;
		it.list_byte = b;
		it.end_of_list = eol;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Hold the input side until every expected entry has arrived
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (expected_entries.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_probe_limit(logic [6:0] value);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		probe_limit_q = value;
	endtask

	// Send the built list, end of list on its last byte
	task automatic send_list();
		foreach (list_bytes[i])
			send_item(list_bytes[i], i == list_bytes.size() - 1);
		list_bytes.delete();
	endtask

	// ---------------------------------------------------------------- list builders

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			list_bytes.push_back(s[i]);
	endfunction

	function automatic void push_number(int unsigned v);
		push_text($sformatf("%0d", v));
	endfunction

	function automatic logic [7:0] host_char();
		int k;
		k = $urandom_range(0, 63);
		if (k < 26)
			return 8'("a" + k);
		if (k < 52)
			return 8'("A" + k - 26);
		if (k < 62)
			return 8'("0" + k - 52);
		return (k == 62) ? "." : "-";
	endfunction

	function automatic void push_host(int n);
		repeat (n) list_bytes.push_back(host_char());
	endfunction

	// Append a run of empty tokens
	function automatic void push_commas(int n);
		repeat (n) list_bytes.push_back(CHAR_COMMA);
	endfunction

	function automatic int pick_allowed();
		case ($urandom_range(0, 2))
			0: return PORT_DEFAULT;
			1: return PORT_TLS;
			default: return PORT_ALT;
		endcase
	endfunction

	function automatic logic [6:0] pick_limit();
		case ($urandom_range(0, 9))
			0: return 7'd1;
			1: return 7'd64;
			2: return 7'd0;
			3: return 7'd127;
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	// Append an optional port: good, denied, zero, overflowing, empty or broken
	function automatic void push_port_part();
		int p;
		p = $urandom_range(0, 11);
		if (p < 4)
			return;
		list_bytes.push_back(CHAR_COLON);
		case (p)
			4, 5: push_number(pick_allowed());
			6: push_number($urandom_range(1, 65535));
			7: begin
				push_text("00");
				push_number(pick_allowed());
			end
			8: begin
				case ($urandom_range(0, 4))
					0: push_number(65535);
					1: push_number(65536);
					2: push_number(0);
					3: push_number(99999);
					default: push_number(1);
				endcase
			end
			9: ;
			10: begin
				push_number($urandom_range(1, 999));
				list_bytes.push_back(host_char());
			end
			default: push_number($urandom_range(65536, 999999));
		endcase
	endfunction

	// Append one token; mostly well formed, the rest broken or noise
	function automatic void add_token(bit short_only);
		int    kind;
		string odd;
		odd = " _/@#!?~";
		kind = short_only ? $urandom_range(0, 69) : $urandom_range(0, 99);
		if (kind < 60) begin
			push_host($urandom_range(1, short_only ? 3 : 12));
			if (!short_only || $urandom_range(0, 3) == 0)
				push_port_part();
		end else if (kind < 66) begin
			// empty token
		end else if (kind < 74) begin
			repeat ($urandom_range(1, 4)) list_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 82) begin
			push_host($urandom_range(1, 6));
			list_bytes.push_back(odd[$urandom_range(0, odd.len() - 1)]);
			push_host($urandom_range(0, 6));
		end else if (kind < 88) begin
			list_bytes.push_back(CHAR_COLON);
			push_number(pick_allowed());
		end else if (kind < 94) begin
			push_host($urandom_range(1, 6));
			list_bytes.push_back(CHAR_COLON);
			list_bytes.push_back(CHAR_COLON);
			push_number(pick_allowed());
		end else if (kind < 99) begin
			push_host($urandom_range(1, 4));
			list_bytes.push_back(CHAR_COLON);
			push_number($urandom_range(1, 9));
		end else begin
			push_host($urandom_range(HOST_CAP - 6, HOST_CAP + 2));
			push_port_part();
		end
	endfunction

	function automatic void push_plain_list(int n);
		for (int t = 0; t < n; t++) begin
			if (t != 0)
				list_bytes.push_back(CHAR_COMMA);
			push_host(1);
		end
	endfunction

	// ---------------------------------------------------------------- tests

	// Ports, malformed forms, trailing comma and byte extremes
	task automatic test_token_forms();
		push_text("a:443,b:8000,c:1,:,d:0,e:x");
		send_list();
		push_text("h,");
		send_list();
		list_bytes.push_back(8'h00);
		send_list();
		list_bytes.push_back(8'hFF);
		send_list();
	endtask

	// Probe cap at reset value, at the extremes and beyond the entry count
	task automatic test_probe_limits();
		push_plain_list(17);
		send_list();
		set_probe_limit(7'd1);
		push_text("a,b:443,c:9,d:0");
		send_list();
		set_probe_limit(7'd0);
		push_text("a,b");
		send_list();
		set_probe_limit(7'd64);
		push_commas(ENTRY_CAP - 1);
		push_text("a:443");
		send_list();
		set_probe_limit(7'd127);
		push_plain_list(5);
		list_bytes.push_back(CHAR_COMMA);
		send_list();
		set_probe_limit(PROBE_LIMIT_RESET);
	endtask

	// Host run at the capacity edge
	task automatic test_long_hosts();
		push_host(HOST_CAP - 1);
		push_text(":443");
		send_list();
		push_host(HOST_CAP);
		send_list();
	endtask

	// Lists with more tokens than entries
	task automatic test_fallback();
		// fallback on a comma, then drop the rest of the list
		push_commas(ENTRY_CAP + 1);
		repeat (5) list_bytes.push_back(8'($urandom_range(0, 255)));
		send_list();
		// trailing comma whose empty token overflows
		push_commas(ENTRY_CAP);
		send_list();
		// trailing comma that itself overflows
		push_commas(ENTRY_CAP + 1);
		send_list();
		// last byte of the list overflows
		push_commas(ENTRY_CAP);
		list_bytes.push_back("a");
		send_list();
	endtask

	// Random lists, random cap changes, calm at the end
	task automatic test_random_lists();
		int n_tok;
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				set_probe_limit(pick_limit());
			if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			n_tok = (TOTAL_ITEMS - items_sent > 400 && $urandom_range(0, 14) == 0)
				? $urandom_range(ENTRY_CAP - 2, ENTRY_CAP + 4) : $urandom_range(1, 8);
			for (int t = 0; t < n_tok; t++) begin
				if (t != 0)
					list_bytes.push_back(CHAR_COMMA);
				add_token(n_tok > 8);
			end
			if (list_bytes.size() == 0 || $urandom_range(0, 3) == 0)
				list_bytes.push_back(CHAR_COMMA);
			send_list();
		end
	endtask

	// Reset, run the tests in turn, drain and report
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		clear_list();
		probe_limit_q = PROBE_LIMIT_RESET;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_token_forms();
		test_probe_limits();
		test_long_hosts();
		test_fallback();
		test_random_lists();

		wait_quiet();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_entries.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
